@@ rtl/rgbhsl_pkg.sv @@
package rgbhsl_pkg;

  localparam int PIX_W   = 8;
  localparam int HUE_W   = 13;
  localparam int SAT_W   = 11;
  localparam int LUM_W   = 11;

  // One quotient bit is resolved per divider stage.
  localparam int QBITS   = 13;
  localparam int REM_W   = 21;
  localparam int NUM_W   = 23;
  localparam int SNUM_W  = 19;
  localparam int LX_W    = 17;
  localparam int LPROD_W = 35;

  // Hue in sixteenths of a degree, percentages in sixteenths of a percent.
  localparam int HUE_SCALE = 960;
  localparam int HUE_GREEN = 1920;
  localparam int HUE_BLUE  = 3840;
  localparam int HUE_FULL  = 5760;
  localparam int PCT_SCALE = 1600;
  localparam int SUM_MID   = 255;
  localparam int SUM_FULL  = 510;

  // Luminance is s*1600/510 = s*160/51. The division by 51 is a multiply by
  // ceil(2^23/51) followed by a shift, exact over the whole range of s*160.
  localparam int LUM_NUM   = 160;
  localparam int LUM_RECIP = 164483;
  localparam int LUM_SHIFT = 23;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic               valid;
    logic               gray;
    logic [PIX_W-1:0]   dvh;
    logic [PIX_W-1:0]   dvs;
    logic [REM_W-1:0]   remh;
    logic [REM_W-1:0]   rems;
    logic [QBITS-1:0]   qh;
    logic [QBITS-1:0]   qs;
    logic [LUM_W-1:0]   lum;
  } div_stage_t;

endpackage

@@ rtl/rgb_to_hsl_core.sv @@
// Pipeline: the input register, stage 1, stage 2, the divider stages and the
// output register lie between the edge that accepts a pixel and out_valid.
// Throughput: one pixel per clock; busy is always low. The hue and saturation
// dividers resolve one quotient bit per stage over 13 stages.
// Reset: rst_n is synchronous and active low and clears every valid bit;
// results are not held back, since the receiver cannot stall.
module rgb_to_hsl_core
  import rgbhsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  output logic             out_valid,
  output logic [HUE_W-1:0] out_hue,
  output logic [SAT_W-1:0] out_saturation,
  output logic [LUM_W-1:0] out_luminance
);

  // Input register stage.
  logic             a_valid_r;
  logic [PIX_W-1:0] a_red_r, a_green_r, a_blue_r;

  // Stage 1: max, min and channel differences.
  logic             b_valid_r, b_valid_nxt;
  max_sel_t         b_sel_r, b_sel_nxt;
  logic [PIX_W-1:0] b_d_r, b_d_nxt;
  logic [PIX_W:0]   b_s_r, b_s_nxt;
  logic [PIX_W:0]   b_diff_r, b_diff_nxt;
  logic [PIX_W-1:0] mx, mn;

  // Stage 2: dividends, divisors and the luminance product operand.
  logic              c_valid_r;
  logic              c_gray_r, c_gray_nxt;
  logic [PIX_W-1:0]  c_dvh_r, c_dvs_r, c_dvs_nxt;
  logic [REM_W-1:0]  c_remh_r, c_remh_nxt;
  logic [SNUM_W-1:0] c_rems_r, c_rems_nxt;
  logic [LX_W-1:0]   c_lx_r, c_lx_nxt;
  logic [NUM_W-1:0]  diff_ext, base_c, num_c;

  // Divider stages.
  div_stage_t st_r   [QBITS];
  div_stage_t st_nxt [QBITS];
  div_stage_t src    [QBITS];
  logic [LPROD_W-1:0] lprod_r, lprod_nxt;
  logic [REM_W-1:0]   shh, shs;

  logic             out_valid_r;
  logic [HUE_W-1:0] out_hue_r;
  logic [SAT_W-1:0] out_saturation_r;
  logic [LUM_W-1:0] out_luminance_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
    a_red_r   <= in_red;
    a_green_r <= in_green;
    a_blue_r  <= in_blue;
  end

  // Ties go to red first, then green.
  always_comb begin
    if (a_red_r >= a_green_r && a_red_r >= a_blue_r) begin
      b_sel_nxt  = MAX_RED;
      mx         = a_red_r;
      b_diff_nxt = {1'b0, a_green_r} - {1'b0, a_blue_r};
    end else if (a_green_r >= a_blue_r) begin
      b_sel_nxt  = MAX_GREEN;
      mx         = a_green_r;
      b_diff_nxt = {1'b0, a_blue_r} - {1'b0, a_red_r};
    end else begin
      b_sel_nxt  = MAX_BLUE;
      mx         = a_blue_r;
      b_diff_nxt = {1'b0, a_red_r} - {1'b0, a_green_r};
    end
    mn = a_red_r;
    if (a_green_r < mn) begin
      mn = a_green_r;
    end
    if (a_blue_r < mn) begin
      mn = a_blue_r;
    end
    b_d_nxt     = mx - mn;
    b_s_nxt     = {1'b0, mx} + {1'b0, mn};
    b_valid_nxt = a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
    b_sel_r  <= b_sel_nxt;
    b_d_r    <= b_d_nxt;
    b_s_r    <= b_s_nxt;
    b_diff_r <= b_diff_nxt;
  end

  // The hue dividend is kept in two's complement; a negative value (red
  // largest, green below blue) gets a full turn added before the divide.
  always_comb begin
    diff_ext = {{(NUM_W-PIX_W-1){b_diff_r[PIX_W]}}, b_diff_r};
    case (b_sel_r)
      MAX_GREEN: base_c = NUM_W'(HUE_GREEN);
      MAX_BLUE:  base_c = NUM_W'(HUE_BLUE);
      default:   base_c = '0;
    endcase
    num_c = diff_ext * NUM_W'(HUE_SCALE) + base_c * NUM_W'(b_d_r);
    if (num_c[NUM_W-1]) begin
      num_c = num_c + NUM_W'(HUE_FULL) * NUM_W'(b_d_r);
    end
    c_remh_nxt = num_c[REM_W-1:0];
    c_rems_nxt = SNUM_W'(b_d_r) * SNUM_W'(PCT_SCALE);
    if (b_s_r < (PIX_W+1)'(SUM_MID)) begin
      c_dvs_nxt = b_s_r[PIX_W-1:0];
    end else begin
      c_dvs_nxt = 8'((PIX_W+1)'(SUM_FULL) - b_s_r);
    end
    c_lx_nxt   = LX_W'(b_s_r) * LX_W'(LUM_NUM);
    c_gray_nxt = (b_d_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_gray_r <= c_gray_nxt;
    c_dvh_r  <= b_d_r;
    c_dvs_r  <= c_dvs_nxt;
    c_remh_r <= c_remh_nxt;
    c_rems_r <= c_rems_nxt;
    c_lx_r   <= c_lx_nxt;
  end

  // Restoring division, most significant quotient bit first. A gray pixel
  // divides by zero here; its hue and saturation are forced to zero at the end.
  always_comb begin
    src[0].valid = c_valid_r;
    src[0].gray  = c_gray_r;
    src[0].dvh   = c_dvh_r;
    src[0].dvs   = c_dvs_r;
    src[0].remh  = c_remh_r;
    src[0].rems  = REM_W'(c_rems_r);
    src[0].qh    = '0;
    src[0].qs    = '0;
    src[0].lum   = '0;
    for (int k = 1; k < QBITS; k++) begin
      src[k] = st_r[k-1];
    end
    for (int k = 0; k < QBITS; k++) begin
      st_nxt[k] = src[k];
      shh = REM_W'(src[k].dvh) << (QBITS - 1 - k);
      shs = REM_W'(src[k].dvs) << (QBITS - 1 - k);
      if (src[k].remh >= shh) begin
        st_nxt[k].remh              = src[k].remh - shh;
        st_nxt[k].qh[QBITS - 1 - k] = 1'b1;
      end
      if (src[k].rems >= shs) begin
        st_nxt[k].rems              = src[k].rems - shs;
        st_nxt[k].qs[QBITS - 1 - k] = 1'b1;
      end
    end
    lprod_nxt     = LPROD_W'(c_lx_r) * LPROD_W'(LUM_RECIP);
    st_nxt[1].lum = lprod_r[LUM_SHIFT + LUM_W - 1:LUM_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QBITS; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else begin
      for (int k = 0; k < QBITS; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
    lprod_r <= lprod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st_r[QBITS-1].valid;
    end
    out_hue_r        <= st_r[QBITS-1].gray ? '0 : st_r[QBITS-1].qh[HUE_W-1:0];
    out_saturation_r <= st_r[QBITS-1].gray ? '0 : st_r[QBITS-1].qs[SAT_W-1:0];
    out_luminance_r  <= st_r[QBITS-1].lum;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_saturation_r;
  assign out_luminance  = out_luminance_r;

endmodule

@@ verif/hsl_checker.sv @@
// Watches both channels of the converter, predicts the hue, saturation and
// luminance of every accepted pixel, and compares each result in order.
module hsl_checker
  import rgbhsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  input  logic             out_valid,
  input  logic [HUE_W-1:0] out_hue,
  input  logic [SAT_W-1:0] out_saturation,
  input  logic [LUM_W-1:0] out_luminance,
  output int               mismatch_cnt,
  output int               pending
);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [LUM_W-1:0] lum;
  } hsl_t;

  hsl_t hsl_q[$];
  hsl_t head;

  function automatic hsl_t hsl_of_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] b);
    int       rv, gv, bv, mx, mn, d, s, num, base;
    max_sel_t lead;
    hsl_t     res;
    rv = r;
    gv = g;
    bv = b;
    // Strict compares keep red ahead of green, and green ahead of blue, on ties.
    mx = rv;
    lead = MAX_RED;
    if (gv > mx) begin
      mx = gv;
      lead = MAX_GREEN;
    end
    if (bv > mx) begin
      mx = bv;
      lead = MAX_BLUE;
    end
    mn = rv;
    if (gv < mn) mn = gv;
    if (bv < mn) mn = bv;
    d = mx - mn;
    s = mx + mn;
    res = '0;
    res.lum = LUM_W'((s * PCT_SCALE) / SUM_FULL);
    if (d > 0) begin
      if (s < SUM_MID) begin
        res.sat = SAT_W'((d * PCT_SCALE) / s);
      end else begin
        res.sat = SAT_W'((d * PCT_SCALE) / (SUM_FULL - s));
      end
      case (lead)
        MAX_RED: begin
          num = (gv - bv) * HUE_SCALE;
          base = 0;
        end
        MAX_GREEN: begin
          num = (bv - rv) * HUE_SCALE;
          base = HUE_GREEN;
        end
        default: begin
          num = (rv - gv) * HUE_SCALE;
          base = HUE_BLUE;
        end
      endcase
      // A hue below zero wraps around the circle before truncation.
      num = num + base * d;
      if (num < 0) num = num + HUE_FULL * d;
      num = num / d;
      if (num >= HUE_FULL) num = num - HUE_FULL;
      res.hue = HUE_W'(num);
    end
    return res;
  endfunction

  initial begin
    mismatch_cnt = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hsl_q.delete();
    end else begin
      if (out_valid) begin
        if (hsl_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: result with no pixel outstanding: hue %0d sat %0d lum %0d",
                     $realtime, out_hue, out_saturation, out_luminance);
          mismatch_cnt++;
        end else begin
          head = hsl_q.pop_front();
          if (head.hue !== out_hue || head.sat !== out_saturation ||
              head.lum !== out_luminance) begin
            if (mismatch_cnt < 10)
              $display("%0t: expected hue %0d sat %0d lum %0d, got hue %0d sat %0d lum %0d",
                       $realtime, head.hue, head.sat, head.lum,
                       out_hue, out_saturation, out_luminance);
            mismatch_cnt++;
          end
        end
      end
      if (start && !busy) hsl_q.push_back(hsl_of_pixel(in_red, in_green, in_blue));
    end
    pending = hsl_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top
  import rgbhsl_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  logic             out_valid;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_saturation;
  logic [LUM_W-1:0] out_luminance;
  int               mismatch_cnt;
  int               pending;
  int               cycle_cnt;

  rgb_to_hsl_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_luminance (out_luminance)
  );

  hsl_checker hsl_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_luminance (out_luminance),
    .mismatch_cnt  (mismatch_cnt),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one pixel, after idling the share of cycles given by idle_pct,
  // and returns at the edge that accepts the transaction.
  task automatic send_pixel(input int r, input int g, input int b, input int idle_pct);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_red <= PIX_W'(r);
    in_green <= PIX_W'(g);
    in_blue <= PIX_W'(b);
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // Full-range pixels for a third of the draws, with a good share of near-gray, tied and
  // saturated colors, and pixels right at the lightness midpoint.
  task automatic random_pixel(output int r, output int g, output int b);
    int base;
    case ($urandom_range(5))
      0: begin
        base = $urandom_range(255);
        r = base;
        g = base;
        b = $urandom_range(base);
        if ($urandom_range(1)) begin
          g = b;
          b = base;
        end
      end
      1: begin
        base = $urandom_range(2, 253);
        r = base + $urandom_range(2) - 1;
        g = base + $urandom_range(2) - 1;
        b = base + $urandom_range(2) - 1;
      end
      2: begin
        r = $urandom_range(1) ? 255 : $urandom_range(255);
        g = $urandom_range(1) ? 0 : $urandom_range(255);
        b = $urandom_range(1) ? 255 : 0;
      end
      3: begin
        // Max plus min lands on either side of 255.
        base = $urandom_range(128, 255);
        r = base;
        g = 254 - base + $urandom_range(2);
        b = $urandom_range(g, base);
      end
      default: begin
        r = $urandom_range(255);
        g = $urandom_range(255);
        b = $urandom_range(255);
      end
    endcase
    if ($urandom_range(2) == 0) begin
      base = r;
      case ($urandom_range(2))
        0: begin
          r = g;
          g = base;
        end
        1: begin
          r = b;
          b = base;
        end
        default: begin
          r = b;
          b = g;
          g = base;
        end
      endcase
    end
  endtask

  task automatic random_phase(input int count, input int idle_pct);
    int r, g, b;
    for (int i = 0; i < count; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b, idle_pct);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Black, white and mid gray, then the primaries and secondaries.
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 0);
    send_pixel(255, 255, 0, 0);
    send_pixel(255, 0, 255, 0);
    send_pixel(0, 255, 255, 0);
    // Red largest with blue above green, so the raw hue is negative.
    send_pixel(255, 0, 10, 0);
    send_pixel(200, 99, 100, 0);
    send_pixel(1, 0, 1, 0);
    // Ties for the largest channel.
    send_pixel(90, 90, 30, 0);
    send_pixel(90, 30, 90, 0);
    send_pixel(30, 90, 90, 0);
    // Lightness just below, at and just above the midpoint, then near black, near white and other mixes.
    send_pixel(254, 0, 0, 0);
    send_pixel(200, 55, 100, 0);
    send_pixel(200, 56, 100, 0);
    send_pixel(0, 1, 0, 0);
    send_pixel(255, 254, 255, 0);
    send_pixel(170, 85, 0, 0);
    send_pixel(0, 127, 128, 0);

    random_phase(250, 0);
    // Let the pipeline empty completely before the next burst.
    start <= 1'b0;
    wait (pending == 0);
    @(posedge clk);
    random_phase(300, 59);
    random_phase(280, 25);
    start <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ rgb_to_hsl_core.f @@
rtl/rgbhsl_pkg.sv
rtl/rgb_to_hsl_core.sv
verif/hsl_checker.sv
verif/tb_top.sv
